// ----- rtl/core/dbnc_pkg.sv -----
// Package: shared types, constants and command codes of the input debouncer.
`default_nettype none

package dbnc_pkg;

    localparam int CHANNELS  = 32;
    localparam int MAX_LANES = 32;
    localparam int LANES     = (CHANNELS > MAX_LANES) ? MAX_LANES : CHANNELS;
    localparam int LANE_W    = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CNT_W     = 8;
    localparam int CH_W      = 6;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_SET  = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t            command;
        logic [31:0]     raw_levels;
        logic [CH_W-1:0] channel;
        logic            debounce_enable;
        logic [7:0]      debounce_ticks;
    } cmd_beat_t;

    typedef struct packed {
        logic [31:0] debounced_levels;
        logic        setting_accepted;
    } rsp_beat_t;

    // One channel's setting, as held in the setting memory
    typedef struct packed {
        logic             enable;
        logic [CNT_W-1:0] ticks;
    } lane_cfg_t;

    // Per-channel view handed to the update logic
    typedef struct packed {
        lane_cfg_t        cfg;
        logic [CNT_W-1:0] count;
        logic             cur;
        logic             old;
    } lane_state_t;

    localparam int CFG_W = $bits(lane_cfg_t);

endpackage

`default_nettype wire

// ----- rtl/core/dbnc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module dbnc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic                                   rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/dbnc_lane.sv -----
// Per-channel counter update: mismatch count, threshold test, level adoption.
`default_nettype none

module dbnc_lane
    import dbnc_pkg::*;
(
    input  wire lane_state_t      lane,
    output logic [CNT_W-1:0]      count_next,
    output logic                  adopt
);

    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] bumped;

    always_comb
    begin
        limit  = lane.cfg.enable ? lane.cfg.ticks : '0;
        bumped = (lane.count != CNT_MAX) ? lane.count + CNT_W'(1) : lane.count;
        adopt  = 1'b0;
        if (lane.cur != lane.old)
        begin
            if (bumped >= limit)
            begin
                adopt      = 1'b1;
                count_next = '0;
            end
            else
            begin
                count_next = bumped;
            end
        end
        else
        begin
            count_next = '0;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/multi_channel_input_debouncer_unit.sv -----
// Top level: multi-channel counter-based input debouncer.
//
//   port group  dir  type        beat
//   cmd_*       in   cmd_beat_t  tick (raw sample vector) or set (one channel's setting)
//   rsp_*       out  rsp_beat_t  debounced vector after the beat, setting_accepted flag
//
// A tick walks the channels one per cycle, paced by the single read port of the count
// and setting memories. A set beat writes the setting memory in its acceptance cycle;
// one beat per cycle while no result waits in the pending slot.
// Reset clears the debounced vector and the per-entry valid bits (an entry never written
// reads as zero); no clearing pass, the block is ready right after reset.
// A stalled result sits in the output register (or one pending slot) while the next
// beat is taken; cmd_ready drops while a tick is being walked or a result waits in
// the pending slot.
`default_nettype none

module multi_channel_input_debouncer_unit
    import dbnc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_ready,
    input  wire cmd_beat_t cmd_beat,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output rsp_beat_t      rsp_beat
);

    // walk control
    logic              issue_reg;
    logic [LANE_W-1:0] iss_idx_reg;
    logic              s2_valid_reg;
    logic              s2_last_reg;
    logic [LANE_W-1:0] s2_idx_reg;
    logic [31:0]       raw_reg;

    // debounced vector
    logic [31:0]       stable_reg;
    logic [31:0]       stable_next;

    // valid bits standing in for the all-zero reset of both memories
    logic [LANES-1:0]  cnt_vld_reg;
    logic [LANES-1:0]  cfg_vld_reg;
    logic              cnt_rd_vld_reg;
    logic              cfg_rd_vld_reg;

    // result path
    logic              rsp_valid_reg;
    rsp_beat_t         rsp_beat_reg;
    logic              pend_reg;
    logic              pend_acc_reg;

    logic              accept;
    logic              acc_tick;
    logic              acc_set;
    logic              set_hit;
    logic              busy;
    logic              slot_free;
    logic              done;
    logic              done_acc;

    logic [CNT_W-1:0]  cnt_rd_data;
    logic [CFG_W-1:0]  cfg_rd_data;
    lane_state_t       lane;
    logic [CNT_W-1:0]  cnt_wr_data;
    logic              adopt;
    lane_cfg_t         set_cfg;

    assign busy      = issue_reg | s2_valid_reg;
    assign cmd_ready = ~busy & ~pend_reg;
    assign accept    = cmd_valid & cmd_ready;
    assign acc_tick  = accept & (cmd_beat.command == CMD_TICK);
    assign acc_set   = accept & (cmd_beat.command == CMD_SET);
    assign set_hit   = ({1'b0, cmd_beat.channel} < 7'(LANES));
    assign slot_free = ~rsp_valid_reg | rsp_ready;

    assign set_cfg.enable = cmd_beat.debounce_enable;
    assign set_cfg.ticks  = cmd_beat.debounce_ticks;

    // Count memory: read-modify-write during the walk. Reads and the writeback of
    // the same entry never overlap: the walk reads ahead by one entry and a new beat
    // is taken only after the last writeback.
    dbnc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (LANES)
    ) u_cnt_ram (
        .clk     (clk),
        .wr_en   (s2_valid_reg),
        .wr_addr (s2_idx_reg),
        .wr_data (cnt_wr_data),
        .rd_en   (issue_reg),
        .rd_addr (iss_idx_reg),
        .rd_data (cnt_rd_data)
    );

    // Setting memory: written by set beats (only while no walk runs), read by the walk.
    dbnc_ram #(
        .WIDTH (CFG_W),
        .DEPTH (LANES)
    ) u_cfg_ram (
        .clk     (clk),
        .wr_en   (acc_set & set_hit),
        .wr_addr (cmd_beat.channel[LANE_W-1:0]),
        .wr_data (set_cfg),
        .rd_en   (issue_reg),
        .rd_addr (iss_idx_reg),
        .rd_data (cfg_rd_data)
    );

    always_comb
    begin
        lane.cfg   = cfg_rd_vld_reg ? lane_cfg_t'(cfg_rd_data) : '0;
        lane.count = cnt_rd_vld_reg ? cnt_rd_data : '0;
        lane.cur   = raw_reg[5'(s2_idx_reg)];
        lane.old   = stable_reg[5'(s2_idx_reg)];
    end

    dbnc_lane u_lane (
        .lane       (lane),
        .count_next (cnt_wr_data),
        .adopt      (adopt)
    );

    always_comb
    begin
        stable_next = stable_reg;
        if (s2_valid_reg && adopt)
        begin
            stable_next[5'(s2_idx_reg)] = lane.cur;
        end
    end

    // A result is ready at the end of a walk or in the cycle a set beat is taken.
    assign done     = acc_set | (s2_valid_reg & s2_last_reg);
    assign done_acc = acc_set & set_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg      <= 1'b0;
            iss_idx_reg    <= '0;
            s2_valid_reg   <= 1'b0;
            s2_last_reg    <= 1'b0;
            s2_idx_reg     <= '0;
            raw_reg        <= '0;
            stable_reg     <= '0;
            cnt_vld_reg    <= '0;
            cfg_vld_reg    <= '0;
            cnt_rd_vld_reg <= 1'b0;
            cfg_rd_vld_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            pend_reg       <= 1'b0;
            pend_acc_reg   <= 1'b0;
        end
        else
        begin
            // read issue, one channel per cycle; the raw sample is held for the walk
            if (acc_tick)
            begin
                issue_reg   <= 1'b1;
                iss_idx_reg <= '0;
                raw_reg     <= cmd_beat.raw_levels;
            end
            else if (issue_reg)
            begin
                if (iss_idx_reg == LANE_W'(LANES - 1))
                begin
                    issue_reg <= 1'b0;
                end
                else
                begin
                    iss_idx_reg <= iss_idx_reg + LANE_W'(1);
                end
            end

            s2_valid_reg <= issue_reg;
            s2_idx_reg   <= iss_idx_reg;
            s2_last_reg  <= (iss_idx_reg == LANE_W'(LANES - 1));
            if (issue_reg)
            begin
                cnt_rd_vld_reg <= cnt_vld_reg[iss_idx_reg];
                cfg_rd_vld_reg <= cfg_vld_reg[iss_idx_reg];
            end

            // writeback
            stable_reg <= stable_next;
            if (s2_valid_reg)
            begin
                cnt_vld_reg[s2_idx_reg] <= 1'b1;
            end
            if (acc_set && set_hit)
            begin
                cfg_vld_reg[cmd_beat.channel[LANE_W-1:0]] <= 1'b1;
            end

            // result register and pending slot
            if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (done)
            begin
                if (slot_free)
                begin
                    rsp_valid_reg <= 1'b1;
                end
                else
                begin
                    pend_reg     <= 1'b1;
                    pend_acc_reg <= done_acc;
                end
            end
            else if (pend_reg && slot_free)
            begin
                rsp_valid_reg <= 1'b1;
                pend_reg      <= 1'b0;
            end
        end
    end

    // Result payload. The debounced vector does not move while a result is pending,
    // so the pending slot only keeps the flag.
    always_ff @(posedge clk)
    begin
        if (done && slot_free)
        begin
            rsp_beat_reg.debounced_levels <= stable_next;
            rsp_beat_reg.setting_accepted <= done_acc;
        end
        else if (pend_reg && slot_free)
        begin
            rsp_beat_reg.debounced_levels <= stable_reg;
            rsp_beat_reg.setting_accepted <= pend_acc_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_beat  = rsp_beat_reg;

endmodule

`default_nettype wire

// ----- rtl/core/dbnc_checker.sv -----
// Port-level checker for the debouncer, bound to the top level.
`default_nettype none

module dbnc_port_checker
    import dbnc_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      cmd_valid,
    input wire logic      cmd_ready,
    input wire cmd_beat_t cmd_beat,
    input wire logic      rsp_valid,
    input wire logic      rsp_ready,
    input wire rsp_beat_t rsp_beat
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_beat))
    else $error("result beat changed while stalled");

    // a tick occupies the walk, so no beat is taken in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_beat.command == CMD_TICK |=> !cmd_ready)
    else $error("beat taken while a tick is being walked");

    // a set beat with a free output answers in the next cycle with the range check
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_beat.command == CMD_SET && (!rsp_valid || rsp_ready)
        |=> rsp_valid
            && rsp_beat.setting_accepted == ($past({1'b0, cmd_beat.channel}) < 7'(LANES)))
    else $error("set result missing or wrong flag");

    // a tick result cannot appear in the cycle after the tick is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_beat.command == CMD_TICK && !rsp_valid |=> !rsp_valid)
    else $error("tick result appeared too early");

endmodule

bind multi_channel_input_debouncer_unit dbnc_port_checker u_dbnc_port_checker (.*);

`default_nettype wire

// ----- bench/dbnc_checker.sv -----
// Checker: mirrors the debouncer state, predicts each response beat and compares it.
module dbnc_checker
    import dbnc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  logic      cmd_ready,
    input  cmd_beat_t cmd_beat,
    input  logic      rsp_valid,
    input  logic      rsp_ready,
    input  rsp_beat_t rsp_beat,
    output int        fail_count,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // mirrored block state
    logic [31:0]      level_model;
    logic [CNT_W-1:0] run_count [LANES];
    lane_cfg_t        lane_setting [LANES];

    // responses still owed by the block, oldest first
    rsp_beat_t debounced_q [$];
    rsp_beat_t want;

    int fail_total  = 0;
    int outstanding = 0;

    assign fail_count = fail_total;
    assign pending    = outstanding;

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] exp_val);
        if (fail_total < 100)
            $display("ERROR %0t ns %s: got %h, expected %h", $time, what, got, exp_val);
        fail_total = fail_total + 1;
    endtask

    // Advance the mirrored state by one command beat, return the response it owes.
    task apply_command(input cmd_beat_t b, output rsp_beat_t r);
        logic [CNT_W-1:0] limit;
        r = '0;
        if (b.command == CMD_TICK)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                limit = lane_setting[i].enable ? lane_setting[i].ticks : '0;
                if (b.raw_levels[i] != level_model[i])
                begin
                    if (run_count[i] != CNT_MAX)
                        run_count[i] = run_count[i] + 1'b1;
                    if (run_count[i] >= limit)
                    begin
                        level_model[i] = b.raw_levels[i];
                        run_count[i]   = '0;
                    end
                end
                else
                begin
                    run_count[i] = '0;
                end
            end
        end
        else if (b.channel < LANES)
        begin
            lane_setting[b.channel[LANE_W-1:0]].enable = b.debounce_enable;
            lane_setting[b.channel[LANE_W-1:0]].ticks  = b.debounce_ticks;
            r.setting_accepted = 1'b1;
        end
        r.debounced_levels = level_model;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_model = '0;
            for (int i = 0; i < LANES; i++)
            begin
                run_count[i]    = '0;
                lane_setting[i] = '0;
            end
            debounced_q.delete();
            outstanding <= 0;
        end
        else
        begin
            // response side first: a beat taken this edge cannot be answered at this edge
            if (rsp_valid && rsp_ready)
            begin
                if (debounced_q.size() == 0)
                begin
                    report_mismatch("response with nothing outstanding",
                                    rsp_beat.debounced_levels, '0);
                end
                else
                begin
                    want = debounced_q.pop_front();
                    if (rsp_beat.debounced_levels !== want.debounced_levels)
                        report_mismatch("debounced_levels", rsp_beat.debounced_levels,
                                        want.debounced_levels);
                    if (rsp_beat.setting_accepted !== want.setting_accepted)
                        report_mismatch("setting_accepted",
                                        32'(rsp_beat.setting_accepted),
                                        32'(want.setting_accepted));
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                apply_command(cmd_beat, want);
                debounced_q.push_back(want);
            end
            outstanding <= debounced_q.size();
        end
    end

endmodule

// ----- bench/tb_multi_channel_input_debouncer_unit.sv -----
// Testbench top: drives command beats into the debouncer and gives the verdict.
module tb_multi_channel_input_debouncer_unit;
    import dbnc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // total command beats: ~25 directed, the rest random
    localparam int BEAT_TARGET    = 1050;
    // cycles with no beat on either side before the run is called hung;
    // a tick walk plus the worst stalls on both sides stays well under it
    localparam int WATCHDOG_LIMIT = 1000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_ready;
    cmd_beat_t cmd_beat  = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_beat_t rsp_beat;

    int fail_count;
    int pending;
    int beats_sent = 0;

    // burst modes switch idling off for a while on each side
    bit cmd_burst = 1'b0;
    bit rsp_burst = 1'b0;

    multi_channel_input_debouncer_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_beat  (cmd_beat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_beat  (rsp_beat)
    );

    dbnc_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_beat   (cmd_beat),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_beat   (rsp_beat),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Tick beat: the set fields ride along as noise and must be ignored.
    function automatic cmd_beat_t tick_of(input logic [31:0] raw);
        cmd_beat_t b;
        b.command         = CMD_TICK;
        b.raw_levels      = raw;
        b.channel         = 6'($urandom_range(0, 63));
        b.debounce_enable = 1'($urandom_range(0, 1));
        b.debounce_ticks  = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // Set beat: the raw vector is noise here.
    function automatic cmd_beat_t setting_of(input logic [5:0] ch, input logic en,
                                             input logic [7:0] ticks);
        cmd_beat_t b;
        b.command         = CMD_SET;
        b.raw_levels      = $urandom;
        b.channel         = ch;
        b.debounce_enable = en;
        b.debounce_ticks  = ticks;
        return b;
    endfunction

    // Thresholds lean on the extremes and on small counts that actually trip.
    function automatic logic [7:0] pick_threshold();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd255;
            3:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(2, 15));
        endcase
    endfunction

    // Present one beat after a random gap and hold it until taken.
    // Valid is only lowered when a gap is drawn, so back-to-back beats
    // never see a low/high pair in one time step.
    task send_beat(input cmd_beat_t b);
        int gap;
        if ($urandom_range(0, 49) == 0)
            cmd_burst = !cmd_burst;
        gap = cmd_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_beat  <= b;
        do @(posedge clk); while (!cmd_ready);
        beats_sent++;
    endtask

    // Response side: random stall before each beat, then wait for the handshake.
    initial
    begin
        int stall;
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 49) == 0)
                rsp_burst = !rsp_burst;
            stall = rsp_burst ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    // Watchdog: any beat on either side restarts the count.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL multi_channel_input_debouncer_unit");
        $finish;
    end

    initial
    begin
        int          sel;
        int          run_len;
        bit          long_run;
        logic [31:0] base;
        logic [31:0] glitch;
        logic [5:0]  ch;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed ----
        // all settings zero after reset: every difference is adopted at once
        send_beat(tick_of(32'hFFFF_FFFF));
        send_beat(tick_of(32'h0000_0000));
        // enabled with zero ticks behaves like one tick
        send_beat(setting_of(6'd0, 1'b1, 8'd0));
        // top channel, longest setting
        send_beat(setting_of(6'd31, 1'b1, 8'd255));
        // first and last channel past the end: ignored, not accepted
        send_beat(setting_of(6'd32, 1'b1, 8'd5));
        send_beat(setting_of(6'd63, 1'b0, 8'd255));
        send_beat(setting_of(6'd5, 1'b1, 8'd3));
        // disabled channel with a nonzero count: threshold is still zero
        send_beat(setting_of(6'd7, 1'b0, 8'd200));
        send_beat(setting_of(6'd9, 1'b1, 8'd10));
        // ch0 and ch7 flip now; ch5, ch9 start counting
        send_beat(tick_of(32'h0000_02A1));
        send_beat(tick_of(32'h8000_02A1));
        // ch5 glitches back to its stable level: its count clears
        send_beat(tick_of(32'h8000_0281));
        send_beat(tick_of(32'h8000_02A1));
        send_beat(tick_of(32'h8000_02A1));
        // drop ch9 below its running count: next differing tick adopts
        send_beat(setting_of(6'd9, 1'b1, 8'd2));
        send_beat(tick_of(32'h8000_02A1));
        send_beat(setting_of(6'd5, 1'b0, 8'd3));
        send_beat(tick_of(32'h8000_0000));
        send_beat(tick_of(32'h0000_0000));
        send_beat(setting_of(6'd31, 1'b1, 8'd1));
        send_beat(tick_of(32'hFFFF_FFFF));
        send_beat(tick_of(32'h5555_5555));
        send_beat(tick_of(32'hAAAA_AAAA));

        // ---- random ----
        // Mostly runs of steady levels with sparse glitches so counters get
        // to their thresholds; an occasional long clean hold reaches 255.
        while (beats_sent < BEAT_TARGET)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 2)
            begin
                ch = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(32, 63))
                                                 : 6'($urandom_range(0, 31));
                send_beat(setting_of(ch, 1'($urandom_range(0, 3) != 0), pick_threshold()));
            end
            else if (sel == 2)
            begin
                send_beat(tick_of($urandom));
            end
            else
            begin
                long_run = ($urandom_range(0, 29) == 0);
                run_len  = long_run ? $urandom_range(200, 280) : $urandom_range(1, 12);
                base     = $urandom;
                for (int k = 0; k < run_len && beats_sent < BEAT_TARGET; k++)
                begin
                    glitch = long_run ? '0 : ($urandom & $urandom & $urandom);
                    send_beat(tick_of(base ^ glitch));
                end
            end
        end

        // ---- drain ----
        cmd_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        // catch any stray extra response
        repeat (LANES + 8) @(posedge clk);

        if (fail_count == 0)
            $display("PASS multi_channel_input_debouncer_unit");
        else
            $display("FAIL multi_channel_input_debouncer_unit");
        $finish;
    end

endmodule
